// ----- hdl/cdhs_pkg.sv -----
// Shared constants, word types and coefficient tables for the concentric
// disk to cosine hemisphere sampler. No dependencies.
package cdhs_pkg;

  // Field widths
  localparam int SEED_BITS     = 16;
  localparam int OUT_FRAC_BITS = 15;

  // Internal fixed-point fraction bits
  localparam int QF = 30;
  localparam logic [QF:0]   QONE   = (QF+1)'(1) << QF;
  localparam logic [QF-1:0] PI_4_Q = QF'(843314857);

  // Horner steps with a true constant divide (the final cos step halves)
  localparam int TRIG_STEPS = 4;
  // Reciprocals ceil(2^(QF+sh)/k), exact floor division for values below 2^QF
  localparam logic [30:0] SIN_RECIP [TRIG_STEPS] =
    '{31'd1908874354, 31'd1636178018, 31'd1717986919, 31'd1431655766}; // 72 42 20 6
  localparam int SIN_SH [TRIG_STEPS] = '{7, 6, 5, 3};
  localparam logic [30:0] COS_RECIP [TRIG_STEPS] =
    '{31'd1527099484, 31'd1227133514, 31'd1145324613, 31'd1431655766}; // 90 56 30 12
  localparam int COS_SH [TRIG_STEPS] = '{7, 6, 5, 4};

  // Unit latencies in register stages
  localparam int DIV_LAT  = QF + 1;
  localparam int TRIG_LAT = 2*TRIG_STEPS + 2;
  localparam int SQRT_LAT = QF + 1;

  typedef struct packed {
    logic [SEED_BITS-1:0] seed_u;
    logic [SEED_BITS-1:0] seed_v;
  } in_word_t;

  typedef struct packed {
    logic signed [OUT_FRAC_BITS:0] dir_x;
    logic signed [OUT_FRAC_BITS:0] dir_y;
    logic [OUT_FRAC_BITS-1:0]      dir_z;
  } out_word_t;

endpackage

// ----- hdl/cdhs_div.sv -----
// Pipelined restoring divider: (minor << QF) / major, one quotient bit a stage.
// Depends on cdhs_pkg.
module cdhs_div import cdhs_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [SEED_BITS:0] minor,
  input  logic [SEED_BITS:0] major,
  output logic [QF:0]        quo
);

  localparam int RW = SEED_BITS + 1;

  logic [RW-1:0] rem_r  [DIV_LAT];
  logic [RW-1:0] den_r  [DIV_LAT];
  logic          zero_r [DIV_LAT];
  logic [QF:0]   quo_r  [DIV_LAT];

  for (genvar k = 0; k < DIV_LAT; k++) begin : g_step
    logic [RW:0]   part;
    logic [RW:0]   diff;
    logic [RW-1:0] den_in;
    logic          zero_in;
    logic [QF:0]   quo_in;
    logic          qbit;

    // first stage sees the minor itself, later ones the shifted remainder
    if (k == 0) begin : g_first
      assign part    = {1'b0, minor};
      assign den_in  = major;
      assign zero_in = (major == '0);
      assign quo_in  = '0;
    end else begin : g_next
      assign part    = {rem_r[k-1], 1'b0};
      assign den_in  = den_r[k-1];
      assign zero_in = zero_r[k-1];
      assign quo_in  = quo_r[k-1];
    end

    assign diff = part - {1'b0, den_in};
    assign qbit = (part >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= qbit ? diff[RW-1:0] : part[RW-1:0];
        den_r[k]  <= den_in;
        zero_r[k] <= zero_in;
        quo_r[k]  <= {quo_in[QF-1:0], qbit};
      end
    end
  end

  // zero major means the exact centre: ratio is taken as zero
  assign quo = zero_r[DIV_LAT-1] ? '0 : quo_r[DIV_LAT-1];

endmodule

// ----- hdl/cdhs_trig.sv -----
// Pipelined sine and cosine in Q30 by Horner-form series, two lanes side by side.
// Depends on cdhs_pkg.
module cdhs_trig import cdhs_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [QF-1:0] phi,
  output logic [QF:0]   sin_q,
  output logic [QF:0]   cos_q
);

  localparam int NS = 2*TRIG_STEPS + 1;
  localparam int PW = 2*QF + 2;

  logic [QF-1:0] x_r   [NS];
  logic [QF-1:0] phi_r [NS];
  logic [QF:0]   sp_r  [NS];
  logic [QF:0]   cp_r  [NS];
  logic [QF:0]   sin_r;
  logic [QF:0]   cos_r;

  logic [2*QF-1:0] phi_sq;
  logic [2*QF:0]   sin_fin;
  logic [2*QF:0]   cos_fin;
  logic [2*QF:0]   cos_half;

  // stage 0: square of the angle
  assign phi_sq = phi * phi;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]   <= phi_sq[2*QF-1:QF];
      phi_r[0] <= phi;
      sp_r[0]  <= QONE;
      cp_r[0]  <= QONE;
    end
  end

  // each Horner step: multiply by x, then divide by a constant and subtract
  for (genvar j = 0; j < TRIG_STEPS; j++) begin : g_horner
    localparam int A = 2*j + 1;
    localparam int B = 2*j + 2;
    logic [2*QF:0] mul_s;
    logic [2*QF:0] mul_c;
    logic [PW-1:0] rs;
    logic [PW-1:0] rc;
    logic [PW-1:0] qs;
    logic [PW-1:0] qc;

    assign mul_s = x_r[A-1] * sp_r[A-1];
    assign mul_c = x_r[A-1] * cp_r[A-1];
    assign rs    = PW'(sp_r[A]) * PW'(SIN_RECIP[j]);
    assign rc    = PW'(cp_r[A]) * PW'(COS_RECIP[j]);
    assign qs    = rs >> (QF + SIN_SH[j]);
    assign qc    = rc >> (QF + COS_SH[j]);

    always_ff @(posedge clk) begin
      if (en) begin
        sp_r[A]  <= mul_s[2*QF:QF];
        cp_r[A]  <= mul_c[2*QF:QF];
        x_r[A]   <= x_r[A-1];
        phi_r[A] <= phi_r[A-1];
        sp_r[B]  <= QONE - qs[QF:0];
        cp_r[B]  <= QONE - qc[QF:0];
        x_r[B]   <= x_r[A];
        phi_r[B] <= phi_r[A];
      end
    end
  end

  // last stage: sin = phi*p, cos = 1 - x*p/2
  assign sin_fin  = phi_r[NS-1] * sp_r[NS-1];
  assign cos_fin  = x_r[NS-1] * cp_r[NS-1];
  assign cos_half = cos_fin >> (QF + 1);

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= sin_fin[2*QF:QF];
      cos_r <= QONE - cos_half[QF:0];
    end
  end

  assign sin_q = sin_r;
  assign cos_q = cos_r;

endmodule

// ----- hdl/cdhs_sqrt.sv -----
// Pipelined integer square root, one result bit a stage, floor result.
// Depends on cdhs_pkg.
module cdhs_sqrt import cdhs_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  logic [2*QF:0]   rad,
  output logic [QF:0]     root
);

  localparam int NW = 2*QF + 1;

  logic [NW-1:0] rad_r [SQRT_LAT];
  logic [NW-1:0] res_r [SQRT_LAT];

  for (genvar k = 0; k < SQRT_LAT; k++) begin : g_step
    localparam int I = QF - k;
    logic [NW-1:0] n_in;
    logic [NW-1:0] r_in;
    logic [NW:0]   trial;
    logic [NW:0]   bitv;
    logic          take;

    if (k == 0) begin : g_first
      assign n_in = rad;
      assign r_in = '0;
    end else begin : g_next
      assign n_in = rad_r[k-1];
      assign r_in = res_r[k-1];
    end

    assign bitv  = (NW+1)'(1) << (2*I);
    assign trial = {1'b0, r_in} + bitv;
    assign take  = ({1'b0, n_in} >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k] <= take ? (n_in - trial[NW-1:0]) : n_in;
        res_r[k] <= take ? ((r_in >> 1) + bitv[NW-1:0]) : (r_in >> 1);
      end
    end
  end

  assign root = res_r[SQRT_LAT-1][QF:0];

endmodule

// ----- hdl/concentric_disk_hemisphere_sample_top.sv -----
// Top level of the concentric disk to cosine hemisphere sampler.
// Depends on cdhs_pkg, cdhs_div, cdhs_trig and cdhs_sqrt.
//
// Takes one pair of uniform seeds per cycle while not stalled and returns one
// hemisphere direction per pair, in order. Each pair passes through the
// 31-stage bit-per-stage divider that forms the minor/major ratio, the angle
// multiply, the ten-stage sine/cosine pipeline, the radius product and the
// output register; z runs beside them through a 31-stage square root. A stall
// on the output while a word is valid freezes the pipeline as a whole and
// stalls the input in that cycle.
module concentric_disk_hemisphere_sample_top import cdhs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  localparam int SW       = SEED_BITS + 1;
  localparam int SIDE_DLY = DIV_LAT + 1 + TRIG_LAT;
  localparam int Z_DLY    = SIDE_DLY + 1 - (2 + SQRT_LAT);
  localparam int PIPE_LAT = SIDE_DLY + 3;
  localparam int PROD_W   = SEED_BITS + QF + 2;
  localparam int XY_SH    = SEED_BITS + QF - OUT_FRAC_BITS;
  localparam int MAG_W    = PROD_W + 1 - XY_SH;
  localparam int Z_SH     = QF - OUT_FRAC_BITS;
  localparam int RQ_W     = SEED_BITS + 1 + QF;

  typedef struct packed {
    logic [SW-1:0] major;
    logic          swap;
    logic          nx;
    logic          ny;
  } side_t;

  logic                adv;
  logic [PIPE_LAT-1:0] vld_r;

  // ---- stage 0: fold seeds to signed magnitudes
  logic [SW-1:0] two_u, two_v, ax, ay;
  logic          nx, ny;
  side_t         s0_nxt, s0_r;
  logic [SW-1:0] minor_r;

  assign two_u = {in_word.seed_u, 1'b0};
  assign two_v = {in_word.seed_v, 1'b0};

  always_comb begin
    nx = (two_u < (SW'(1) << SEED_BITS));
    ny = (two_v < (SW'(1) << SEED_BITS));
    ax = nx ? ((SW'(1) << SEED_BITS) - two_u) : (two_u - (SW'(1) << SEED_BITS));
    ay = ny ? ((SW'(1) << SEED_BITS) - two_v) : (two_v - (SW'(1) << SEED_BITS));
    s0_nxt.swap  = (ax > ay);
    s0_nxt.major = s0_nxt.swap ? ax : ay;
    s0_nxt.nx    = nx;
    s0_nxt.ny    = ny;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r    <= s0_nxt;
      minor_r <= s0_nxt.swap ? ay : ax;
    end
  end

  // ---- ratio, angle, sine and cosine
  logic [QF:0]     t_q;
  logic [2*QF:0]   phi_prod;
  logic [QF-1:0]   phi_r;
  logic [QF:0]     sin_q, cos_q;

  cdhs_div u_div (
    .clk   (clk),
    .en    (adv),
    .minor (minor_r),
    .major (s0_r.major),
    .quo   (t_q)
  );

  assign phi_prod = t_q * PI_4_Q;

  always_ff @(posedge clk) begin
    if (adv) begin
      phi_r <= phi_prod[2*QF-1:QF];
    end
  end

  cdhs_trig u_trig (
    .clk   (clk),
    .en    (adv),
    .phi   (phi_r),
    .sin_q (sin_q),
    .cos_q (cos_q)
  );

  // ---- z path: rq^2, 1 - rq^2, square root
  logic [RQ_W-1:0] rq_wide;
  logic [QF:0]     rq;
  logic [2*QF+1:0] sq_nxt, sq_r;
  logic [2*QF+1:0] rad_full;
  logic [2*QF:0]   rad_r;
  logic [QF:0]     root;
  logic [QF:0]     z_dly_r [Z_DLY];

  assign rq_wide  = {s0_r.major, QF'(0)} >> SEED_BITS;
  assign rq       = rq_wide[QF:0];
  assign sq_nxt   = rq * rq;
  assign rad_full = ((2*QF+2)'(1) << (2*QF)) - sq_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r  <= sq_nxt;
      rad_r <= rad_full[2*QF:0];
    end
  end

  cdhs_sqrt u_sqrt (
    .clk  (clk),
    .en   (adv),
    .rad  (rad_r),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      z_dly_r[0] <= root;
      for (int i = 1; i < Z_DLY; i++) begin
        z_dly_r[i] <= z_dly_r[i-1];
      end
    end
  end

  // ---- side information travels alongside the ratio and trig units
  side_t side_r [SIDE_DLY];

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= s0_r;
      for (int i = 1; i < SIDE_DLY; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // ---- radius products
  side_t             sd;
  logic [PROD_W-1:0] px_nxt, py_nxt, px_r, py_r;
  logic              pnx_r, pny_r;

  assign sd     = side_r[SIDE_DLY-1];
  assign px_nxt = PROD_W'(sd.major) * PROD_W'(sd.swap ? cos_q : sin_q);
  assign py_nxt = PROD_W'(sd.major) * PROD_W'(sd.swap ? sin_q : cos_q);

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r  <= px_nxt;
      py_r  <= py_nxt;
      pnx_r <= sd.nx;
      pny_r <= sd.ny;
    end
  end

  // ---- rounding and saturation into the output register
  function automatic logic [OUT_FRAC_BITS:0] sat_xy(input logic [PROD_W-1:0] prod,
                                                   input logic neg);
    logic [PROD_W:0]  sum;
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] lim;
    sum = {1'b0, prod} + ((PROD_W+1)'(1) << (XY_SH - 1));
    mag = sum[PROD_W:XY_SH];
    lim = MAG_W'(1) << OUT_FRAC_BITS;
    if (neg) begin
      if (mag > lim) begin
        mag = lim;
      end
      sat_xy = (OUT_FRAC_BITS+1)'(MAG_W'(0) - mag);
    end else begin
      if (mag > lim - MAG_W'(1)) begin
        mag = lim - MAG_W'(1);
      end
      sat_xy = mag[OUT_FRAC_BITS:0];
    end
  endfunction

  logic [QF+1:0]            zmag;
  logic [OUT_FRAC_BITS-1:0] z_sat;
  out_word_t                out_nxt, out_word_r;

  if (Z_SH > 0) begin : g_zround
    logic [QF+1:0] zsum;
    assign zsum = {1'b0, z_dly_r[Z_DLY-1]} + ((QF+2)'(1) << (Z_SH - 1));
    assign zmag = zsum >> Z_SH;
  end else begin : g_zshift
    assign zmag = {1'b0, z_dly_r[Z_DLY-1]} << (-Z_SH);
  end

  always_comb begin
    if (zmag > (QF+2)'((QF+2)'(1) << OUT_FRAC_BITS) - (QF+2)'(1)) begin
      z_sat = '1;
    end else begin
      z_sat = zmag[OUT_FRAC_BITS-1:0];
    end
    out_nxt.dir_x = sat_xy(px_r, pnx_r);
    out_nxt.dir_y = sat_xy(py_r, pny_r);
    out_nxt.dir_z = z_sat;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word_r <= out_nxt;
    end
  end

  // ---- valid chain and flow control
  assign adv = !(vld_r[PIPE_LAT-1] && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], in_valid};
    end
  end

  assign in_stall  = !adv;
  assign out_valid = vld_r[PIPE_LAT-1];
  assign out_word  = out_word_r;

  // ---- checks
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("valid chain moved during a stall");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> vld_r[0])
    else $error("accepted word not in first stage");

  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    adv && vld_r[PIPE_LAT-2] |=> out_valid)
    else $error("word lost before output register");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !vld_r[PIPE_LAT-2] |=> !out_valid)
    else $error("word repeated at output");

endmodule

// ----- tb/tb_concentric_disk_hemisphere_sample_top.sv -----
// Testbench for the concentric disk to cosine hemisphere sampler.
// Depends on cdhs_pkg and concentric_disk_hemisphere_sample_top; predicts each
// direction word in fixed point and checks it against the output stream.
module tb_concentric_disk_hemisphere_sample_top;
  import cdhs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 45;
  localparam int N_RANDOM = 1600;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  in_word_t  seed_q[$];
  out_word_t dir_expected[$];
  int        n_errors = 0;
  bit        hold_rx = 1'b0;
  int        burst_left = 0;
  int        gap_left = 0;
  bit        drain_pause = 1'b0;

  concentric_disk_hemisphere_sample_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Q30 fixed-point helpers
  function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
    mul_q30 = (a * b) >> 30;
  endfunction

  function automatic logic [63:0] sine_q30(input logic [63:0] a);
    logic [63:0] x, p;
    x = mul_q30(a, a);
    p = 64'd1 << 30;
    p = (64'd1 << 30) - mul_q30(x, p) / 72;
    p = (64'd1 << 30) - mul_q30(x, p) / 42;
    p = (64'd1 << 30) - mul_q30(x, p) / 20;
    p = (64'd1 << 30) - mul_q30(x, p) / 6;
    sine_q30 = mul_q30(a, p);
  endfunction

  function automatic logic [63:0] cosine_q30(input logic [63:0] a);
    logic [63:0] x, p;
    x = mul_q30(a, a);
    p = 64'd1 << 30;
    p = (64'd1 << 30) - mul_q30(x, p) / 90;
    p = (64'd1 << 30) - mul_q30(x, p) / 56;
    p = (64'd1 << 30) - mul_q30(x, p) / 30;
    p = (64'd1 << 30) - mul_q30(x, p) / 12;
    p = (64'd1 << 30) - mul_q30(x, p) / 2;
    cosine_q30 = p;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    int_sqrt = res;
  endfunction

  // Clamp a magnitude and apply the sign of the seed
  function automatic logic [15:0] signed_dir(input logic [63:0] mag, input bit neg);
    if (neg) begin
      if (mag > 64'd32768) mag = 64'd32768;
      signed_dir = 16'(64'd0 - mag);
    end else begin
      if (mag > 64'd32767) mag = 64'd32767;
      signed_dir = 16'(mag);
    end
  endfunction

  function automatic out_word_t hemisphere_dir(input in_word_t w);
    logic [63:0] ax, ay, major, minor, ratio, phi, sn, cs, mx, my, rq, z;
    bit          nx, ny;
    out_word_t   r;
    nx = (w.seed_u < 16'h8000);
    ny = (w.seed_v < 16'h8000);
    ax = nx ? 64'd65536 - 2 * w.seed_u : 2 * w.seed_u - 64'd65536;
    ay = ny ? 64'd65536 - 2 * w.seed_v : 2 * w.seed_v - 64'd65536;
    major = (ax > ay) ? ax : ay;
    minor = (ax > ay) ? ay : ax;
    ratio = (major == 0) ? 64'd0 : (minor << 30) / major;
    phi = (ratio * 64'd843314857) >> 30;
    sn = sine_q30(phi);
    cs = cosine_q30(phi);
    // shift from Q(16+30) down to Q15 with round half up
    mx = (major * ((ax > ay) ? cs : sn) + (64'd1 << 30)) >> 31;
    my = (major * ((ax > ay) ? sn : cs) + (64'd1 << 30)) >> 31;
    rq = (major << 30) >> 16;
    z = int_sqrt((64'd1 << 60) - rq * rq);
    z = (z + (64'd1 << 14)) >> 15;
    if (z > 64'd32767) z = 64'd32767;
    r.dir_x = signed_dir(mx, nx);
    r.dir_y = signed_dir(my, ny);
    r.dir_z = 15'(z);
    hemisphere_dir = r;
  endfunction

  // Driver: bursts and gaps, holds the word while stalled
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        dir_expected.push_back(hemisphere_dir(in_word));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (seed_q.size() > 0 && !drain_pause) begin
          in_word  <= seed_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(40, 1);
            gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern and output check
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (dir_expected.size() == 0) begin
          $display("%0t: unexpected word %h", $time, out_word);
          n_errors++;
        end else begin
          e = dir_expected.pop_front();
          if (e.dir_x !== out_word.dir_x)
            $display("%0t: dir_x exp %0d got %0d", $time, e.dir_x, out_word.dir_x);
          if (e.dir_y !== out_word.dir_y)
            $display("%0t: dir_y exp %0d got %0d", $time, e.dir_y, out_word.dir_y);
          if (e.dir_z !== out_word.dir_z)
            $display("%0t: dir_z exp %0d got %0d", $time, e.dir_z, out_word.dir_z);
          if (e !== out_word) n_errors++;
        end
      end
      out_stall <= hold_rx || ($urandom_range(7, 0) < 2 && $time % 4000 > 1500);
    end
  end

  // Long receiver hold-off while the sender keeps offering
  initial begin
    repeat (300) @(posedge clk);
    hold_rx = 1'b1;
    repeat (150) @(posedge clk);
    hold_rx = 1'b0;
  end

  initial begin
    in_word_t w;
    int       edges [8] = '{0, 1, 16'h7fff, 16'h8000, 16'h8001, 16'hfffe, 16'hffff, 16'h4000};
    // directed: corners, centre, edges, diagonal
    foreach (edges[i]) foreach (edges[j]) begin
      if (i < 5 || j < 3) begin
        w.seed_u = 16'(edges[i]);
        w.seed_v = 16'(edges[j]);
        seed_q.push_back(w);
      end
    end
    for (int k = 0; k < N_RANDOM; k++) begin
      w.seed_u = 16'($urandom_range(65535, 0));
      w.seed_v = ($urandom_range(9, 0) == 0) ? w.seed_u : 16'($urandom_range(65535, 0));
      seed_q.push_back(w);
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // pause the sender once until everything is back
    wait (seed_q.size() < 900);
    drain_pause = 1'b1;
    wait (dir_expected.size() == 0 && !in_valid);
    drain_pause = 1'b0;
    wait (seed_q.size() == 0);
    @(posedge clk);
    wait (!in_valid);
    wait (dir_expected.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (n_errors == 0 && dir_expected.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
